FILE: hw/rtl/four_digit_seven_segment_number_display_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the seven-segment display block
// Concurrent checks that vanish when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef FOUR_DIGIT_SEVEN_SEGMENT_NUMBER_DISPLAY_DEFINES_SVH
`define FOUR_DIGIT_SEVEN_SEGMENT_NUMBER_DISPLAY_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define FDSSD_ASSERT_IMP(label, clk_s, rstn_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define FDSSD_ASSERT_NXT(label, clk_s, rstn_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);
`else
`define FDSSD_ASSERT_IMP(label, clk_s, rstn_s, ante, cons, msg)
`define FDSSD_ASSERT_NXT(label, clk_s, rstn_s, ante, cons, msg)
`endif
`endif

FILE: hw/rtl/fdssd_pkg.sv
// ----------------------------------------------------------------------------
// fdssd_pkg
// Types, segment codes and scaling constants of the seven-segment display.
// ----------------------------------------------------------------------------
package fdssd_pkg;

  localparam int DIGITS = 4;
  localparam int Q_W    = 14;  // shown number, at most 9999

  typedef logic [7:0] seg_t;

  // active-low segments, bit 7 is the decimal point
  localparam seg_t SEG_BLANK    = 8'hFF;
  localparam seg_t SEG_DASH     = 8'hBF;
  localparam seg_t SEG_DOT      = 8'h7F;
  localparam seg_t SEG_ZERO_DOT = 8'h40;

  typedef enum logic [1:0] {
    KIND_INT  = 2'd0,
    KIND_REAL = 2'd1,
    KIND_TICK = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    MODE_DASH,
    MODE_NUM,
    MODE_NEG_FRAC,
    MODE_POS_FRAC
  } mode_t;

  typedef enum logic [1:0] {
    SCALE_1,
    SCALE_10,
    SCALE_100,
    SCALE_1000
  } scale_t;

  typedef struct packed {
    kind_t      kind;
    mode_t      mode;
    logic       neg;
    logic       dp_en;
    logic [1:0] dp;
  } fmt_ctl_t;

  // floor(n/d) == (n * ceil(2^34/d)) >> 34 for any n below 2^24
  localparam int          RECIP_SHIFT = 34;
  localparam logic [30:0] RECIP_10    = 31'd1717986919;
  localparam logic [30:0] RECIP_100   = 31'd171798692;
  localparam logic [30:0] RECIP_1000  = 31'd17179870;

  // quotients of the shown number (below 2^14)
  localparam logic [12:0] Q10_MUL   = 13'd6554;   // >> 16
  localparam logic [12:0] Q100_MUL  = 13'd5243;   // >> 19
  localparam logic [14:0] Q1000_MUL = 15'd16778;  // >> 24

  function automatic seg_t seg_font(input logic [3:0] digit);
    seg_t pat;
    unique case (digit)
      4'd0:    pat = 8'hC0;
      4'd1:    pat = 8'hF9;
      4'd2:    pat = 8'hA4;
      4'd3:    pat = 8'hB0;
      4'd4:    pat = 8'h99;
      4'd5:    pat = 8'h92;
      4'd6:    pat = 8'h82;
      4'd7:    pat = 8'hF8;
      4'd8:    pat = 8'h80;
      4'd9:    pat = 8'h90;
      default: pat = SEG_BLANK;
    endcase
    return pat;
  endfunction

endpackage

FILE: hw/rtl/fdssd_if.sv
// ----------------------------------------------------------------------------
// fdssd_in_if / fdssd_out_if
// Valid/ready channels of the display block: command items in, glyphs out.
// ----------------------------------------------------------------------------
interface fdssd_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic signed [31:0] value;

  modport source (output valid, output kind, output value, input ready);
  modport sink   (input valid, input kind, input value, output ready);
endinterface

interface fdssd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] segments;
  logic [3:0] digit_select;

  modport source (output valid, output segments, output digit_select, input ready);
  modport sink   (input valid, input segments, input digit_select, output ready);
endinterface

FILE: hw/rtl/fdssd_glyphs.sv
// ----------------------------------------------------------------------------
// fdssd_glyphs
// Splits the shown number into decimal digits and builds the four patterns.
// ----------------------------------------------------------------------------
module fdssd_glyphs (
  input  fdssd_pkg::fmt_ctl_t           ctl_i,
  input  logic [fdssd_pkg::Q_W-1:0]     q_i,
  input  logic [9:0]                    q10_i,
  input  logic [6:0]                    q100_i,
  input  logic [3:0]                    q1000_i,
  output logic [fdssd_pkg::DIGITS-1:0][7:0] pats_o
);
  import fdssd_pkg::*;

  logic [Q_W-1:0] q10x10;
  logic [9:0]     q100x10;
  logic [6:0]     q1000x10;
  logic [3:0]     d0, d1, d2, d3;
  logic           ge10, ge100, ge1000;

  assign q10x10   = Q_W'({q10_i, 3'b000}) + Q_W'({q10_i, 1'b0});
  assign q100x10  = 10'({q100_i, 3'b000}) + 10'({q100_i, 1'b0});
  assign q1000x10 = 7'({q1000_i, 3'b000}) + 7'({q1000_i, 1'b0});

  assign d0 = 4'(q_i - q10x10);
  assign d1 = 4'(q10_i - q100x10);
  assign d2 = 4'(q100_i - q1000x10);
  assign d3 = q1000_i;

  assign ge10   = (q_i >= Q_W'(10));
  assign ge100  = (q_i >= Q_W'(100));
  assign ge1000 = (q_i >= Q_W'(1000));

  always_comb begin
    pats_o = {DIGITS{SEG_BLANK}};
    unique case (ctl_i.mode)
      MODE_DASH: begin
        pats_o = {DIGITS{SEG_DASH}};
      end
      MODE_NUM: begin
        // right-aligned, minus sign just left of the leading digit
        pats_o[3] = seg_font(d0);
        pats_o[2] = ge10   ? seg_font(d1) : (ctl_i.neg ? SEG_DASH : SEG_BLANK);
        pats_o[1] = ge100  ? seg_font(d2)
                           : ((ctl_i.neg && ge10) ? SEG_DASH : SEG_BLANK);
        pats_o[0] = ge1000 ? seg_font(d3)
                           : ((ctl_i.neg && ge100) ? SEG_DASH : SEG_BLANK);
        if (ctl_i.dp_en) begin
          pats_o[ctl_i.dp] = pats_o[ctl_i.dp] & SEG_DOT;
        end
      end
      MODE_NEG_FRAC: begin
        // "-0.dd", hundredths
        pats_o[3] = seg_font(d0);
        pats_o[2] = seg_font(d1);
        pats_o[1] = SEG_ZERO_DOT;
        pats_o[0] = SEG_DASH;
      end
      MODE_POS_FRAC: begin
        // "0.ddd", thousandths
        pats_o[3] = seg_font(d0);
        pats_o[2] = seg_font(d1);
        pats_o[1] = seg_font(d2);
        pats_o[0] = SEG_ZERO_DOT;
      end
    endcase
  end

endmodule

FILE: hw/rtl/four_digit_seven_segment_number_display.sv
// ----------------------------------------------------------------------------
// four_digit_seven_segment_number_display
// Formats integers and fixed-point reals onto four multiplexed digits.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan carries command transactions: kind 0 shows an integer (-999..9999),
//   kind 1 shows a real given in signed thousandths, kind 2 is a scan tick.
//   Kind 3 is dropped. Only ticks give an out_chan transaction: the active-low
//   pattern of the current digit and its one-hot select, then the scan moves
//   one digit right (bit 0 of digit_select is the leftmost digit).
//   Pipeline: input register, reciprocal multiply, quotient multiplies,
//   digit/glyph build with result register. A tick goes via the stage registers
//   to out_chan; while nothing stalls, one transaction per cycle is sustained.
//   Display items update the shown patterns in order with the ticks.
//   Reset blanks all four digits and points the scan at the leftmost digit.
//   When out_chan stalls, a tick waits in the last stage; items behind it
//   fill the stages before it, and in_chan.ready drops once all three are full.
// ----------------------------------------------------------------------------
`include "four_digit_seven_segment_number_display_defines.svh"

module four_digit_seven_segment_number_display (
  input logic       clk,
  input logic       rst_n,
  fdssd_in_if.sink  in_chan,
  fdssd_out_if.source out_chan
);
  import fdssd_pkg::*;

  // ---------------- flow control ----------------
  logic s1_v_r, s2_v_r, s3_v_r, out_v_r;
  logic out_free, s3_go, s3_free, s2_free, s1_free, tick_go, s3_is_tick;

  fmt_ctl_t s2_ctl_r, s3_ctl_r;

  assign out_free   = !out_v_r || out_chan.ready;
  assign s3_is_tick = (s3_ctl_r.kind == KIND_TICK);
  assign s3_go      = s3_v_r && (!s3_is_tick || out_free);
  assign s3_free    = !s3_v_r || s3_go;
  assign s2_free    = !s2_v_r || s3_free;
  assign s1_free    = !s1_v_r || s2_free;
  assign tick_go    = s3_go && s3_is_tick;

  assign in_chan.ready = s1_free;

  // ---------------- stage 1: range check and scaling ----------------
  kind_t              s1_kind_r;
  logic [31:0]        s1_value_r;
  logic               s1_neg;
  logic [31:0]        s1_mag;
  fmt_ctl_t           s1_ctl;
  scale_t             s1_scale;
  logic [30:0]        s1_recip;
  logic [54:0]        s1_prod;
  logic [Q_W-1:0]     s2_q_nxt;

  assign s1_neg = s1_value_r[31];
  assign s1_mag = s1_neg ? (32'd0 - s1_value_r) : s1_value_r;

  always_comb begin
    s1_ctl       = '0;
    s1_ctl.kind  = s1_kind_r;
    s1_ctl.mode  = MODE_DASH;
    s1_ctl.neg   = s1_neg;
    s1_scale     = SCALE_1;
    if (s1_kind_r == KIND_INT) begin
      if ((s1_neg && s1_mag > 32'd999) || (!s1_neg && s1_mag > 32'd9999)) begin
        s1_ctl.mode = MODE_DASH;
      end else begin
        s1_ctl.mode = MODE_NUM;
      end
    end else if (s1_kind_r == KIND_REAL) begin
      s1_ctl.mode  = MODE_NUM;
      s1_ctl.dp_en = 1'b1;
      if ((!s1_neg && s1_mag > 32'd9999000) || (s1_neg && s1_mag > 32'd999000)) begin
        s1_ctl.mode = MODE_DASH;
      end else if (!s1_neg && s1_mag > 32'd999000) begin
        s1_scale  = SCALE_1000;
        s1_ctl.dp = 2'd3;
      end else if (s1_mag >= 32'd100000) begin
        s1_scale  = s1_neg ? SCALE_1000 : SCALE_100;
        s1_ctl.dp = s1_neg ? 2'd3 : 2'd2;
      end else if (s1_mag >= 32'd10000) begin
        s1_scale  = s1_neg ? SCALE_100 : SCALE_10;
        s1_ctl.dp = s1_neg ? 2'd2 : 2'd1;
      end else if (s1_mag >= 32'd1000) begin
        s1_scale  = s1_neg ? SCALE_10 : SCALE_1;
        s1_ctl.dp = s1_neg ? 2'd1 : 2'd0;
      end else if (s1_neg) begin
        s1_scale     = SCALE_10;
        s1_ctl.mode  = MODE_NEG_FRAC;
        s1_ctl.dp_en = 1'b0;
      end else begin
        s1_ctl.mode  = MODE_POS_FRAC;
        s1_ctl.dp_en = 1'b0;
      end
    end
  end

  always_comb begin
    case (s1_scale)
      SCALE_10:   s1_recip = RECIP_10;
      SCALE_100:  s1_recip = RECIP_100;
      SCALE_1000: s1_recip = RECIP_1000;
      default:    s1_recip = '0;
    endcase
  end

  // magnitude is below 2^24 whenever the result is not dashes
  assign s1_prod  = 55'(s1_mag[23:0]) * 55'(s1_recip);
  assign s2_q_nxt = (s1_scale == SCALE_1) ? s1_mag[Q_W-1:0]
                                          : s1_prod[RECIP_SHIFT +: Q_W];

  // ---------------- stage 2: quotients of the shown number ----------------
  logic [Q_W-1:0] s2_q_r;
  logic [26:0]    s2_p10, s2_p100;
  logic [28:0]    s2_p1000;

  assign s2_p10   = 27'(s2_q_r) * 27'(Q10_MUL);
  assign s2_p100  = 27'(s2_q_r) * 27'(Q100_MUL);
  assign s2_p1000 = 29'(s2_q_r) * 29'(Q1000_MUL);

  // ---------------- stage 3: glyphs, pattern store, scan ----------------
  logic [Q_W-1:0]           s3_q_r;
  logic [9:0]               s3_q10_r;
  logic [6:0]               s3_q100_r;
  logic [3:0]               s3_q1000_r;
  logic [DIGITS-1:0][7:0]   s3_pats;
  logic [DIGITS-1:0][7:0]   pat_r;
  logic [1:0]               scan_r;
  seg_t                     out_seg_r;
  logic [DIGITS-1:0]        out_sel_r;

  fdssd_glyphs u_glyphs (
    .ctl_i   (s3_ctl_r),
    .q_i     (s3_q_r),
    .q10_i   (s3_q10_r),
    .q100_i  (s3_q100_r),
    .q1000_i (s3_q1000_r),
    .pats_o  (s3_pats)
  );

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      scan_r  <= 2'd0;
      pat_r   <= {DIGITS{SEG_BLANK}};
    end else begin
      if (s1_free) begin
        s1_v_r <= in_chan.valid;
      end
      if (s2_free) begin
        s2_v_r <= s1_v_r;
      end
      if (s3_free) begin
        s3_v_r <= s2_v_r;
      end
      if (out_free) begin
        out_v_r <= tick_go;
      end
      if (s3_go && (s3_ctl_r.kind == KIND_INT || s3_ctl_r.kind == KIND_REAL)) begin
        pat_r <= s3_pats;
      end
      if (tick_go) begin
        scan_r <= scan_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free && in_chan.valid) begin
      s1_kind_r  <= kind_t'(in_chan.kind);
      s1_value_r <= in_chan.value;
    end
    if (s2_free) begin
      s2_ctl_r <= s1_ctl;
      s2_q_r   <= s2_q_nxt;
    end
    if (s3_free) begin
      s3_ctl_r   <= s2_ctl_r;
      s3_q_r     <= s2_q_r;
      s3_q10_r   <= s2_p10[25:16];
      s3_q100_r  <= s2_p100[25:19];
      s3_q1000_r <= s2_p1000[27:24];
    end
    if (tick_go) begin
      out_seg_r <= pat_r[scan_r];
      out_sel_r <= DIGITS'(1) << scan_r;
    end
  end

  assign out_chan.valid        = out_v_r;
  assign out_chan.segments     = out_seg_r;
  assign out_chan.digit_select = out_sel_r;

  // ---------------- assertions ----------------
  `FDSSD_ASSERT_IMP(a_sel_onehot, clk, rst_n, out_v_r, $onehot(out_sel_r),
                    "digit select not one-hot")
  `FDSSD_ASSERT_NXT(a_scan_step, clk, rst_n, rst_n && tick_go,
                    scan_r == 2'($past(scan_r) + 2'd1), "scan did not advance")
  `FDSSD_ASSERT_IMP(a_tick_stall, clk, rst_n, s3_v_r && s3_is_tick && !s3_go,
                    out_v_r && !out_chan.ready, "tick held without output stall")
  `FDSSD_ASSERT_IMP(a_ready_full, clk, rst_n, !in_chan.ready,
                    s1_v_r && s2_v_r && s3_v_r && !s3_go, "ready low with room in pipe")

endmodule

FILE: test/four_digit_seven_segment_number_display_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// four_digit_seven_segment_number_display_tb
// Drives show-integer, show-real, scan-tick and dropped command transactions
// into the display block under random idling on both channels. A scoreboard
// keeps its own copy of the four digit patterns and the scan position and
// checks every glyph transaction against the oldest expected one.
// ----------------------------------------------------------------------------
module four_digit_seven_segment_number_display_tb;
  import fdssd_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int         ITEM_GOAL   = 1750;
  localparam int         QUIET_TAIL  = 200;
  localparam int         HOLD_CYCLES = 220;
  localparam int         FLUSH_WAIT  = 10;

  localparam seg_t DIGIT_GLYPH [10] = '{
    8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90
  };

  localparam int unsigned INT_EDGES [9] = '{0, 9, 10, 99, 100, 999, 1000, 9999, 10000};
  localparam int unsigned REAL_EDGES [20] = '{
    0, 1, 9, 10, 99, 100, 999, 1000, 9999, 10000, 99999, 100000, 999000,
    999001, 999999, 1000000, 9999000, 9999001, 9999999, 10000000
  };

  typedef struct packed {
    seg_t       segments;
    logic [3:0] digit_select;
  } glyph_t;

  class display_scoreboard;
    seg_t       shown [4];
    logic [1:0] scan_pos;
    glyph_t     due_glyphs [$];
    int         errors;

    function new();
      foreach (shown[i]) shown[i] = SEG_BLANK;
      scan_pos = 2'd0;
      errors   = 0;
    endfunction

    function void put_number(bit neg, int unsigned mag);
      foreach (shown[i]) shown[i] = SEG_BLANK;
      shown[3] = DIGIT_GLYPH[mag % 10];
      if (neg) shown[2] = SEG_DASH;
      if (mag >= 10) begin
        shown[2] = DIGIT_GLYPH[(mag / 10) % 10];
        if (neg) shown[1] = SEG_DASH;
      end
      if (mag >= 100) begin
        shown[1] = DIGIT_GLYPH[(mag / 100) % 10];
        if (neg) shown[0] = SEG_DASH;
      end
      if (mag >= 1000) shown[0] = DIGIT_GLYPH[(mag / 1000) % 10];
    endfunction

    function void put_real(bit neg, int unsigned mag);
      int unsigned q;
      if ((!neg && mag > 9999000) || (neg && mag > 999000)) begin
        foreach (shown[i]) shown[i] = SEG_DASH;
      end else if (!neg && mag > 999000) begin
        put_number(1'b0, mag / 1000);
        shown[3] &= SEG_DOT;
      end else if (mag >= 100000) begin
        if (neg) begin
          put_number(1'b1, mag / 1000);
          shown[3] &= SEG_DOT;
        end else begin
          put_number(1'b0, mag / 100);
          shown[2] &= SEG_DOT;
        end
      end else if (mag >= 10000) begin
        if (neg) begin
          put_number(1'b1, mag / 100);
          shown[2] &= SEG_DOT;
        end else begin
          put_number(1'b0, mag / 10);
          shown[1] &= SEG_DOT;
        end
      end else if (mag >= 1000) begin
        if (neg) begin
          put_number(1'b1, mag / 10);
          shown[1] &= SEG_DOT;
        end else begin
          put_number(1'b0, mag);
          shown[0] &= SEG_DOT;
        end
      end else if (neg) begin
        // "-0.dd": sign is forced to the leftmost digit
        q = mag / 10;
        put_number(q != 0, q);
        if (shown[2] == SEG_DASH || shown[2] == SEG_BLANK) shown[2] = DIGIT_GLYPH[0];
        shown[1] = DIGIT_GLYPH[0] & SEG_DOT;
        shown[0] = SEG_DASH;
      end else begin
        put_number(1'b0, mag);
        if (mag < 100) begin
          shown[1] = DIGIT_GLYPH[0];
          if (mag < 10) begin
            shown[2] = DIGIT_GLYPH[0];
            if (mag < 1) shown[3] = DIGIT_GLYPH[0];
          end
        end
        shown[0] = DIGIT_GLYPH[0] & SEG_DOT;
      end
    endfunction

    function void note_command(logic [1:0] kind, logic [31:0] value);
      bit          neg;
      int unsigned mag;
      glyph_t      g;
      neg = value[31];
      mag = neg ? (32'd0 - value) : value;
      case (kind)
        KIND_INT: begin
          if ((neg && mag > 999) || (!neg && mag > 9999)) begin
            foreach (shown[i]) shown[i] = SEG_DASH;
          end else begin
            put_number(neg, mag);
          end
        end
        KIND_REAL: put_real(neg, mag);
        KIND_TICK: begin
          g.segments     = shown[scan_pos];
          g.digit_select = 4'b0001 << scan_pos;
          due_glyphs.push_back(g);
          scan_pos = scan_pos + 2'd1;
        end
        default: ;  // dropped by the block
      endcase
    endfunction

    function void check_glyph(seg_t segments, logic [3:0] digit_select);
      glyph_t g;
      if (due_glyphs.size() == 0) begin
        $display("%0t: unexpected glyph, expected none, got seg %h sel %b",
                 $time, segments, digit_select);
        errors++;
        return;
      end
      g = due_glyphs.pop_front();
      if (segments !== g.segments) begin
        $display("%0t: segments mismatch, expected %h, got %h", $time, g.segments, segments);
        errors++;
      end
      if (digit_select !== g.digit_select) begin
        $display("%0t: digit_select mismatch, expected %b, got %b",
                 $time, g.digit_select, digit_select);
        errors++;
      end
    endfunction

    function int pending();
      return due_glyphs.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;

  fdssd_in_if  in_chan ();
  fdssd_out_if out_chan ();

  four_digit_seven_segment_number_display i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  display_scoreboard sb;
  int  tx_idle_pct;
  int  rx_idle_pct;
  bit  quiet;
  bit  hold_req;
  int  items_sent;

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ready side: random stall bursts, one long hold-off on request
  initial begin
    int burst;
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_chan.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        out_chan.ready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 99) < rx_idle_pct) begin
        burst = $urandom_range(1, 13);
        out_chan.ready <= 1'b0;
        repeat (burst) @(posedge clk);
        out_chan.ready <= 1'b1;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready)
      sb.check_glyph(out_chan.segments, out_chan.digit_select);
  end

  task automatic send_cmd(input logic [1:0] kind, input logic [31:0] value);
    int gap;
    in_chan.valid <= 1'b1;
    in_chan.kind  <= kind;
    in_chan.value <= value;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    sb.note_command(kind, value);
    if (kind != KIND_UNUSED) items_sent++;
    if (!quiet && $urandom_range(0, 99) < tx_idle_pct) begin
      gap = $urandom_range(1, 13);
      in_chan.valid <= 1'b0;
      in_chan.kind  <= 2'($urandom);
      in_chan.value <= $urandom;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_ticks(input int count);
    repeat (count) send_cmd(KIND_TICK, $urandom);
  endtask

  task automatic drain_glyphs();
    in_chan.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] signed_pick(int unsigned mag);
    return ($urandom_range(0, 1) != 0) ? (32'd0 - mag) : mag;
  endfunction

  function automatic logic [31:0] pick_int_value();
    case ($urandom_range(0, 5))
      0:       return $urandom_range(0, 9);
      1:       return $urandom_range(10, 9999);
      2:       return 32'd0 - $urandom_range(1, 999);
      3:       return signed_pick(INT_EDGES[$urandom_range(0, 8)]);
      4:       return $urandom;
      default: return signed_pick($urandom_range(0, 12000));
    endcase
  endfunction

  function automatic logic [31:0] pick_real_value();
    case ($urandom_range(0, 7))
      0:       return signed_pick($urandom_range(0, 999));
      1:       return signed_pick($urandom_range(1000, 9999));
      2:       return signed_pick($urandom_range(10000, 99999));
      3:       return signed_pick($urandom_range(100000, 999999));
      4:       return signed_pick($urandom_range(999001, 9999999));
      5:       return signed_pick(REAL_EDGES[$urandom_range(0, 19)]);
      6:       return $urandom;
      default: return signed_pick($urandom_range(0, 12000000));
    endcase
  endfunction

  initial begin
    int r;
    sb          = new();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    quiet       = 1'b0;
    hold_req    = 1'b0;
    items_sent  = 0;
    rst_n         <= 1'b0;
    in_chan.valid <= 1'b0;
    in_chan.kind  <= KIND_INT;
    in_chan.value <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: blank after reset, range edges, sign placement, fraction forms
    send_ticks(1);
    send_cmd(KIND_INT, 32'd0 - 32'd999);
    send_ticks(4);
    send_cmd(KIND_INT, 32'd10000);
    send_ticks(1);
    send_cmd(KIND_REAL, 32'd0 - 32'd5);
    send_ticks(2);
    send_cmd(KIND_REAL, 32'd5);
    send_ticks(1);
    send_cmd(KIND_REAL, 32'd9999000);
    send_ticks(1);
    send_cmd(KIND_REAL, 32'd9999001);
    send_ticks(1);
    send_cmd(KIND_REAL, 32'd0 - 32'd999000);
    send_ticks(1);
    send_cmd(KIND_REAL, 32'h8000_0000);
    send_ticks(1);
    send_cmd(KIND_UNUSED, 32'hFFFF_FFFF);
    send_cmd(KIND_INT, 32'h7FFF_FFFF);
    send_ticks(1);
    drain_glyphs();

    while (items_sent < ITEM_GOAL) begin
      if ((items_sent / 250) % 3 == 0) begin
        tx_idle_pct = 0;
        rx_idle_pct = 10;
      end else if ((items_sent / 250) % 3 == 1) begin
        tx_idle_pct = 15;
        rx_idle_pct = 40;
      end else begin
        tx_idle_pct = 40;
        rx_idle_pct = 15;
      end
      quiet = (items_sent >= ITEM_GOAL - QUIET_TAIL);

      if (items_sent >= 600 && items_sent < 620) begin
        // block fills behind a stalled output, then sender waits it out
        hold_req = 1'b1;
        send_ticks(30);
        drain_glyphs();
        items_sent = 620;
      end

      r = $urandom_range(0, 99);
      if (r < 40)      send_cmd(KIND_INT, pick_int_value());
      else if (r < 85) send_cmd(KIND_REAL, pick_real_value());
      else if (r < 90) send_cmd(KIND_UNUSED, $urandom);
      send_ticks((r < 70) ? 4 : $urandom_range(0, 6));
    end

    in_chan.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (FLUSH_WAIT) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
